// ===== rtl/lqgptc_pkg.sv =====
// ----------------------------------------------------------------------------
// lqgptc_pkg
// Shared constants, types and helpers for the point-tracking LQG controller.
// ----------------------------------------------------------------------------
package lqgptc_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 24;
  localparam int CNT_W        = 5;
  localparam int DIV_W        = FRAC_BITS + 2;  // quotient bits for the turn-rate divide
  localparam int PROD_W       = 68;

  localparam logic signed [34:0] CORDIC_GAIN = 35'sd652032874;
  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;

  localparam longint STOP_R_I  = ((longint'(5) <<< FRAC_BITS) + 50) / 100;
  localparam longint V_LIMIT_I = ((longint'(3) <<< FRAC_BITS) + 5) / 10;
  localparam longint W_LIMIT_I = longint'(2) <<< FRAC_BITS;

  localparam logic signed [32:0] STOP_R  = 33'(STOP_R_I);
  localparam logic signed [67:0] STOP_R2 = 68'(STOP_R_I * STOP_R_I);
  localparam logic signed [15:0] V_LIMIT = 16'(V_LIMIT_I);
  localparam logic signed [18:0] W_LIMIT = 19'(W_LIMIT_I);

  typedef enum logic [2:0] {
    CFG_TARGET_X      = 3'd0,
    CFG_TARGET_Y      = 3'd1,
    CFG_LOOK_OFFSET   = 3'd2,
    CFG_LQR_GAIN      = 3'd3,
    CFG_STEP_TIME     = 3'd4,
    CFG_PROCESS_NOISE = 3'd5,
    CFG_MEASURE_NOISE = 3'd6
  } cfg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE, S_CORDIC, S_ZX, S_ZY, S_SEED, S_GDIV, S_KX, S_KY, S_KV, S_ERR,
    S_EX2, S_EY2, S_CHK, S_UX, S_UY, S_PX, S_PY, S_V1, S_V2, S_T1, S_T2,
    S_T, S_WDIV, S_OUT
  } state_e;

  typedef struct packed {
    logic             start;
    logic [32:0]      rem0;
    logic [DIV_W-1:0] low;
    logic [32:0]      divisor;
    logic [CNT_W-1:0] nbits;
  } div_req_t;

  function automatic logic [29:0] atan_q30(input logic [CNT_W-1:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd843314857;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043837;
      5'd3:  r = 30'd133525159;
      5'd4:  r = 30'd67021687;
      5'd5:  r = 30'd33543516;
      5'd6:  r = 30'd16775851;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194283;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048576;
      5'd11: r = 30'd524288;
      5'd12: r = 30'd262144;
      5'd13: r = 30'd131072;
      5'd14: r = 30'd65536;
      5'd15: r = 30'd32768;
      5'd16: r = 30'd16384;
      5'd17: r = 30'd8192;
      5'd18: r = 30'd4096;
      5'd19: r = 30'd2048;
      5'd20: r = 30'd1024;
      5'd21: r = 30'd512;
      5'd22: r = 30'd256;
      5'd23: r = 30'd128;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) r = 32'sh7fffffff;
    else if (v < -68'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // round half up, then floor shift
  function automatic logic signed [67:0] rshr(input logic signed [67:0] v, input int s);
    logic signed [67:0] r;
    r = (v + (68'sd1 <<< (s - 1))) >>> s;
    return r;
  endfunction

endpackage

// ===== rtl/lqgptc_cordic.sv =====
// ----------------------------------------------------------------------------
// lqgptc_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, Q30 sin/cos.
// ----------------------------------------------------------------------------
module lqgptc_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [14:0] heading_i,
  output logic               done_o,
  output logic signed [32:0] cos_o,
  output logic signed [32:0] sin_o
);
  import lqgptc_pkg::*;

  logic signed [32:0] x_q, y_q, x_d, y_d;
  logic signed [34:0] z_q, z_d, z0;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  logic signed [34:0] at;

  assign at = $signed({5'd0, atan_q30(cnt_q)});
  assign z0 = $signed({{20{heading_i[14]}}, heading_i}) <<< 18;

  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0; neg_d = neg_q;
    if (start_i) begin
      x_d = CORDIC_GAIN[32:0];
      y_d = '0;
      cnt_d = '0;
      busy_d = 1'b1;
      // fold angles beyond a quarter turn, negate the result at the end
      if (z0 > HALF_PI_Q30) begin
        z_d = z0 - PI_Q30; neg_d = 1'b1;
      end else if (z0 < -HALF_PI_Q30) begin
        z_d = z0 + PI_Q30; neg_d = 1'b1;
      end else begin
        z_d = z0; neg_d = 1'b0;
      end
    end else if (busy_q) begin
      if (!z_q[34]) begin
        x_d = x_q - (y_q >>> cnt_q);
        y_d = y_q + (x_q >>> cnt_q);
        z_d = z_q - at;
      end else begin
        x_d = x_q + (y_q >>> cnt_q);
        y_d = y_q - (x_q >>> cnt_q);
        z_d = z_q + at;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d; neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign cos_o  = neg_q ? -x_q : x_q;
  assign sin_o  = neg_q ? -y_q : y_q;

endmodule

// ===== rtl/lqgptc_div.sv =====
// ----------------------------------------------------------------------------
// lqgptc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lqgptc_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lqgptc_pkg::div_req_t         req_i,
  output logic                         done_o,
  output logic [lqgptc_pkg::DIV_W-1:0] quot_o
);
  import lqgptc_pkg::*;

  logic [32:0]      rem_q, rem_d, d_q, d_d;
  logic [DIV_W-1:0] low_q, low_d, q_q, q_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [33:0]      r2;
  logic             ge;

  assign r2 = {rem_q, low_q[DIV_W-1]};
  assign ge = r2 >= {1'b0, d_q};

  always_comb begin
    rem_d = rem_q; d_d = d_q; low_d = low_q; q_d = q_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    if (req_i.start) begin
      rem_d = req_i.rem0;
      low_d = req_i.low;
      d_d   = req_i.divisor;
      cnt_d = req_i.nbits;
      q_d   = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? 33'(r2 - {1'b0, d_q}) : r2[32:0];
      low_d = {low_q[DIV_W-2:0], 1'b0};
      q_d   = {q_q[DIV_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; d_q <= d_d; low_q <= low_d; q_q <= q_d;
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

// ===== rtl/lqg_point_tracking_controller_unit.sv =====
// ----------------------------------------------------------------------------
// lqg_point_tracking_controller_unit
// Kalman-filtered LQR point tracker: sequencer around one shared multiplier,
// an iterative CORDIC and a bit-serial divider.
// ----------------------------------------------------------------------------
// Path: CORDIC, gain divide and multiply steps; an arrived tick ends after the
// distance check, a zero or saturating turn rate skips the turn-rate divide, and
// every other tick also runs the turn-rate divide.
// Throughput: one tick at a time; the next input transfer can come in the cycle
// after the result loads, and the result load waits while the output is stalled.
// Reset: estimates cleared, variance 1.0, not seeded, registers at defaults.
module lqg_point_tracking_controller_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] pose_x_i,
  input  logic signed [31:0] pose_y_i,
  input  logic signed [14:0] heading_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] linear_speed_o,
  output logic signed [18:0] angular_speed_o,
  output logic               arrived_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import lqgptc_pkg::*;

  state_e state_q, state_d;

  logic signed [31:0] tx_q, ty_q;
  logic [17:0] look_q;
  logic [20:0] gain_q;
  logic [16:0] dt_q, pn_q, rn_q;

  logic signed [31:0] px_q, py_q, zx_q, zy_q, estx_q, esty_q, ux_q, uy_q;
  logic [31:0]        var_q;
  logic               seeded_q;
  logic [16:0]        g_q;
  logic signed [32:0] ex_q, ey_q;
  logic signed [67:0] p_q, acc_q;
  logic signed [35:0] t_q;
  logic signed [15:0] v_q, lin_q;
  logic signed [18:0] w_q, ang_q;
  logic               arr_q, arrout_q, ovalid_q;

  logic               accept, cordic_done, div_done, can_load;
  logic signed [32:0] cos_w, sin_w;
  logic [DIV_W-1:0]   quot;
  div_req_t           div_req;
  logic signed [33:0] mul_a, mul_b;

  // combinational helpers
  logic signed [31:0] zy_new;
  logic [32:0]        den;
  logic signed [67:0] sum2, vfull, tfull;
  logic               near;
  logic signed [35:0] t_w;
  logic signed [35:0] abs_t;
  logic [33:0]        hi_t;
  logic               wsat;
  logic [DIV_W-1:0]   qclip;
  logic [32:0]        var_add;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign can_load   = !ovalid_q || !out_stall_i;

  lqgptc_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(accept), .heading_i,
    .done_o(cordic_done), .cos_o(cos_w), .sin_o(sin_w)
  );

  lqgptc_div u_div (
    .clk_i, .rst_ni, .req_i(div_req), .done_o(div_done), .quot_o(quot)
  );

  assign zy_new  = sat32(68'(py_q) + rshr(p_q, 30));
  assign den     = {1'b0, var_q} + {16'd0, rn_q};
  assign sum2    = acc_q + p_q;
  assign near    = (ex_q > -STOP_R) && (ex_q < STOP_R) && (ey_q > -STOP_R) &&
                   (ey_q < STOP_R) && (sum2 < STOP_R2);
  assign vfull   = rshr(acc_q + p_q, 30);
  assign tfull   = rshr(acc_q - p_q, 30);
  assign t_w     = tfull[35:0];
  assign abs_t   = t_w[35] ? -t_w : t_w;
  assign hi_t    = abs_t[35:2];
  assign wsat    = hi_t >= {16'd0, look_q};
  assign qclip   = (quot > DIV_W'(W_LIMIT)) ? DIV_W'(W_LIMIT) : quot;
  assign var_add = {1'b0, var_q} + {16'd0, pn_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (accept) state_d = S_CORDIC;
      S_CORDIC: if (cordic_done) state_d = S_ZX;
      S_ZX:     state_d = S_ZY;
      S_ZY:     state_d = S_SEED;
      S_SEED:   state_d = S_GDIV;
      S_GDIV:   if (div_done) state_d = S_KX;
      S_KX:     state_d = S_KY;
      S_KY:     state_d = S_KV;
      S_KV:     state_d = S_ERR;
      S_ERR:    state_d = S_EX2;
      S_EX2:    state_d = S_EY2;
      S_EY2:    state_d = S_CHK;
      S_CHK:    state_d = near ? S_OUT : S_UX;
      S_UX:     state_d = S_UY;
      S_UY:     state_d = S_PX;
      S_PX:     state_d = S_PY;
      S_PY:     state_d = S_V1;
      S_V1:     state_d = S_V2;
      S_V2:     state_d = S_T1;
      S_T1:     state_d = S_T2;
      S_T2:     state_d = S_T;
      S_T:      state_d = (t_w == '0 || wsat) ? S_OUT : S_WDIV;
      S_WDIV:   if (div_done) state_d = S_OUT;
      S_OUT:    if (can_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // multiplier operands and divider requests
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_req = '0;
    case (state_q)
      S_ZX:  begin mul_a = $signed({16'd0, look_q}); mul_b = 34'(cos_w); end
      S_ZY:  begin mul_a = $signed({16'd0, look_q}); mul_b = 34'(sin_w); end
      S_KX:  begin mul_a = $signed({17'd0, g_q}); mul_b = 34'(zx_q) - 34'(estx_q); end
      S_KY:  begin mul_a = $signed({17'd0, g_q}); mul_b = 34'(zy_q) - 34'(esty_q); end
      S_KV:  begin
        mul_a = $signed({2'd0, var_q});
        mul_b = $signed({17'd0, 17'(17'd1 << FRAC_BITS) - g_q});
      end
      S_EX2: begin mul_a = 34'(ex_q); mul_b = 34'(ex_q); end
      S_EY2: begin mul_a = 34'(ey_q); mul_b = 34'(ey_q); end
      S_UX:  begin mul_a = $signed({13'd0, gain_q}); mul_b = 34'(ex_q); end
      S_UY:  begin mul_a = $signed({13'd0, gain_q}); mul_b = 34'(ey_q); end
      S_PX:  begin mul_a = $signed({17'd0, dt_q}); mul_b = 34'(ux_q); end
      S_PY:  begin mul_a = $signed({17'd0, dt_q}); mul_b = 34'(uy_q); end
      S_V1:  begin mul_a = 34'(cos_w); mul_b = 34'(ux_q); end
      S_V2:  begin mul_a = 34'(sin_w); mul_b = 34'(uy_q); end
      S_T1:  begin mul_a = 34'(cos_w); mul_b = 34'(uy_q); end
      S_T2:  begin mul_a = 34'(sin_w); mul_b = 34'(ux_q); end
      S_SEED: begin
        // var << F over var + R; quotient fits F+1 bits
        div_req.start   = 1'b1;
        div_req.rem0    = {2'd0, var_q[31:1]};
        div_req.low     = {var_q[0], {(DIV_W-1){1'b0}}};
        div_req.divisor = den;
        div_req.nbits   = CNT_W'(FRAC_BITS + 1);
      end
      S_T: begin
        div_req.start   = (t_w != '0) && !wsat;
        div_req.rem0    = hi_t[32:0];
        div_req.low     = {abs_t[1:0], {FRAC_BITS{1'b0}}};
        div_req.divisor = {15'd0, look_q};
        div_req.nbits   = CNT_W'(DIV_W);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tx_q <= 32'sd655360;
      ty_q <= 32'sd655360;
      look_q <= 18'd6554;
      gain_q <= 21'd177053;
      dt_q <= 17'd6554;
      pn_q <= 17'd655;
      rn_q <= 17'd3277;
      estx_q <= '0;
      esty_q <= '0;
      var_q <= 32'd65536;
      seeded_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_TARGET_X:      tx_q <= cfg_data_i;
          CFG_TARGET_Y:      ty_q <= cfg_data_i;
          CFG_LOOK_OFFSET:   look_q <= cfg_data_i[17:0];
          CFG_LQR_GAIN:      gain_q <= cfg_data_i[20:0];
          CFG_STEP_TIME:     dt_q <= cfg_data_i[16:0];
          CFG_PROCESS_NOISE: pn_q <= cfg_data_i[16:0];
          CFG_MEASURE_NOISE: rn_q <= cfg_data_i[16:0];
          default: ;
        endcase
      end
      case (state_q)
        S_SEED: begin
          if (!seeded_q) begin
            estx_q <= zx_q;
            esty_q <= zy_new;
          end
          seeded_q <= 1'b1;
        end
        S_KY:  estx_q <= sat32(68'(estx_q) + rshr(p_q, FRAC_BITS));
        S_KV:  esty_q <= sat32(68'(esty_q) + rshr(p_q, FRAC_BITS));
        S_ERR: var_q <= 32'(rshr(p_q, FRAC_BITS));
        S_PY:  estx_q <= sat32(68'(estx_q) + rshr(p_q, FRAC_BITS));
        S_V1: begin
          esty_q <= sat32(68'(esty_q) + rshr(p_q, FRAC_BITS));
          var_q  <= var_add[32] ? 32'hffffffff : var_add[31:0];
        end
        default: ;
      endcase
      if (state_q == S_OUT && can_load) ovalid_q <= 1'b1;
      else if (!out_stall_i) ovalid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
    if (accept) begin
      px_q <= pose_x_i;
      py_q <= pose_y_i;
    end
    case (state_q)
      S_ZY:   zx_q <= sat32(68'(px_q) + rshr(p_q, 30));
      S_SEED: zy_q <= zy_new;
      S_GDIV: g_q <= (den == '0) ? '0 : quot[16:0];
      S_ERR: begin
        ex_q <= 33'(estx_q) - 33'(tx_q);
        ey_q <= 33'(esty_q) - 33'(ty_q);
      end
      S_EY2: acc_q <= p_q;
      S_CHK: begin
        v_q <= '0;
        w_q <= '0;
        arr_q <= near;
      end
      S_UY:  ux_q <= sat32(-rshr(p_q, FRAC_BITS));
      S_PX:  uy_q <= sat32(-rshr(p_q, FRAC_BITS));
      S_V2:  acc_q <= p_q;
      S_T1: begin
        if (vfull > 68'(V_LIMIT)) v_q <= V_LIMIT;
        else if (vfull < -68'(V_LIMIT)) v_q <= -V_LIMIT;
        else v_q <= vfull[15:0];
      end
      S_T2:  acc_q <= p_q;
      S_T: begin
        t_q <= t_w;
      end
      default: ;
    endcase
    // numerator is complete in S_T; zero or saturated turn rate needs no divide
    if (state_q == S_T) begin
      if (t_w == '0) w_q <= '0;
      else if (wsat) w_q <= t_w[35] ? -W_LIMIT : W_LIMIT;
    end
    if (state_q == S_WDIV && div_done) begin
      w_q <= t_q[35] ? -19'($signed({1'b0, qclip})) : 19'($signed({1'b0, qclip}));
    end
    if (state_q == S_OUT && can_load) begin
      lin_q    <= v_q;
      ang_q    <= w_q;
      arrout_q <= arr_q;
    end
  end

  assign out_valid_o     = ovalid_q;
  assign linear_speed_o  = lin_q;
  assign angular_speed_o = ang_q;
  assign arrived_o       = arrout_q;

endmodule

// ===== verif/lqg_point_tracking_controller_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lqg_point_tracking_controller_unit_test
// Self-checking bench: a directed table, then random control ticks over a range
// of register settings, checked against a behavioral LQG tracking predictor.
// ----------------------------------------------------------------------------
module lqg_point_tracking_controller_unit_test;
  import lqgptc_pkg::*;

  localparam int  ACCEPT_LIMIT = 20000;
  localparam int  LONG_HOLD    = 3000;
  localparam int  PHASE_ITEMS  = 210;
  localparam longint STOP_R_Q  = ((longint'(5) <<< 16) + 50) / 100;
  localparam longint V_LIM_Q   = ((longint'(3) <<< 16) + 5) / 10;
  localparam longint W_LIM_Q   = longint'(2) <<< 16;
  localparam longint PI_Q      = 64'sd3373259426;
  localparam longint HALF_PI_Q = 64'sd1686629713;
  localparam longint GAIN_Q    = 64'sd652032874;

  typedef struct {
    logic [15:0] lin;
    logic [18:0] ang;
    logic        arr;
  } cmd_t;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [14:0] hd;
    bit                 typed;
    cmd_t               cmd;
  } tick_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [31:0] pose_x_i;
  logic signed [31:0] pose_y_i;
  logic signed [14:0] heading_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [15:0] linear_speed_o;
  logic signed [18:0] angular_speed_o;
  logic               arrived_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [31:0]        cfg_data_i;

  // controller state mirror
  longint tgt_x, tgt_y, look_off, lqr_k, dt_q, q_noise, r_noise;
  longint est_x, est_y, est_var;
  bit     est_seeded;

  cmd_t   cmd_q[$];
  bit     cur_typed;
  cmd_t   cur_cmd;
  int     err_cnt;
  int     idle_cnt;
  int     send_idle_pct;
  int     stall_pct;
  int     hold_left;
  longint atan_tab[24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
    131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};

  lqg_point_tracking_controller_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint rnd_shr(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint clip32(longint v);
    return clip(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic void heading_sincos(longint h, output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = h * 262144;
    x = GAIN_Q;
    y = 0;
    flip = 0;
    if (z > HALF_PI_Q) begin
      z -= PI_Q;
      flip = 1;
    end else if (z < -HALF_PI_Q) begin
      z += PI_Q;
      flip = 1;
    end
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic cmd_t track_tick(longint px, longint py, longint h);
    longint c, s, zx, zy, g, ex, ey, ux, uy, v, w, t, den;
    cmd_t r;
    bit near;
    heading_sincos(h, c, s);
    zx = clip32(px + rnd_shr(look_off * c, 30));
    zy = clip32(py + rnd_shr(look_off * s, 30));
    if (!est_seeded) begin
      est_x = zx;
      est_y = zy;
      est_seeded = 1;
    end
    den = est_var + r_noise;
    g = (den != 0) ? (est_var <<< 16) / den : 0;
    est_x = clip32(est_x + rnd_shr(g * (zx - est_x), 16));
    est_y = clip32(est_y + rnd_shr(g * (zy - est_y), 16));
    est_var = rnd_shr(est_var * ((longint'(1) <<< 16) - g), 16);
    ex = est_x - tgt_x;
    ey = est_y - tgt_y;
    near = 0;
    if (ex > -STOP_R_Q && ex < STOP_R_Q && ey > -STOP_R_Q && ey < STOP_R_Q)
      near = (ex * ex + ey * ey) < STOP_R_Q * STOP_R_Q;
    if (near) begin
      r.lin = '0;
      r.ang = '0;
      r.arr = 1'b1;
      return r;
    end
    ux = clip32(-rnd_shr(lqr_k * ex, 16));
    uy = clip32(-rnd_shr(lqr_k * ey, 16));
    est_x = clip32(est_x + rnd_shr(dt_q * ux, 16));
    est_y = clip32(est_y + rnd_shr(dt_q * uy, 16));
    est_var = clip(est_var + q_noise, 0, 64'hFFFFFFFF);
    v = rnd_shr(c * ux + s * uy, 30);
    t = rnd_shr(c * uy - s * ux, 30);
    if (look_off == 0) w = t > 0 ? W_LIM_Q : (t < 0 ? -W_LIM_Q : 0);
    else w = (t * 65536) / look_off;
    v = clip(v, -V_LIM_Q, V_LIM_Q);
    w = clip(w, -W_LIM_Q, W_LIM_Q);
    r.lin = v[15:0];
    r.ang = w[18:0];
    r.arr = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // transfer monitor: prediction on input, comparison on output
  always @(posedge clk_i) begin
    cmd_t want, pred;
    bit   busy_edge;
    if (rst_ni) begin
      busy_edge = 0;
      if (in_valid_i && !in_stall_o) begin
        pred = track_tick(pose_x_i, pose_y_i, heading_i);
        cmd_q.push_back(cur_typed ? cur_cmd : pred);
        busy_edge = 1;
      end
      if (cfg_valid_i && cfg_ready_o) busy_edge = 1;
      if (out_valid_o && !out_stall_i) begin
        busy_edge = 1;
        if (cmd_q.size() == 0) begin
          $display("MISMATCH unexpected result at %0t", $realtime);
          err_cnt++;
        end else begin
          want = cmd_q.pop_front();
          if (linear_speed_o !== want.lin)
            report_mismatch("linear_speed", linear_speed_o, $signed(want.lin));
          if (angular_speed_o !== want.ang)
            report_mismatch("angular_speed", angular_speed_o, $signed(want.ang));
          if (arrived_o !== want.arr)
            report_mismatch("arrived", arrived_o, want.arr);
        end
      end
      idle_cnt <= busy_edge ? 0 : idle_cnt + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cnt >= ACCEPT_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side stall
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_TARGET_X:      tgt_x = longint'($signed(data));
      CFG_TARGET_Y:      tgt_y = longint'($signed(data));
      CFG_LOOK_OFFSET:   look_off = data[17:0];
      CFG_LQR_GAIN:      lqr_k = data[20:0];
      CFG_STEP_TIME:     dt_q = data[16:0];
      CFG_PROCESS_NOISE: q_noise = data[16:0];
      CFG_MEASURE_NOISE: r_noise = data[16:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all(longint tx, longint ty, longint lo, longint k, longint dt,
                           longint qn, longint rn);
    write_reg(CFG_TARGET_X, tx[31:0]);
    write_reg(CFG_TARGET_Y, ty[31:0]);
    write_reg(CFG_LOOK_OFFSET, lo[31:0]);
    write_reg(CFG_LQR_GAIN, k[31:0]);
    write_reg(CFG_STEP_TIME, dt[31:0]);
    write_reg(CFG_PROCESS_NOISE, qn[31:0]);
    write_reg(CFG_MEASURE_NOISE, rn[31:0]);
  endtask

  // called at a falling edge; returns at a falling edge after the transfer
  task automatic send_tick(logic [31:0] px, logic [31:0] py, logic [14:0] hd,
                           bit typed, cmd_t cmd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pose_x_i   <= px;
    pose_y_i   <= py;
    heading_i  <= hd;
    cur_typed  = typed;
    cur_cmd    = cmd;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (cmd_q.size() == 0);
    repeat (150) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_coord(longint center);
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return $urandom;
    if (sel <= 3) return 32'(clip32(center + $signed($urandom_range(26214)) - 13107));
    return 32'(clip32(center + longint'($signed($urandom_range(2621440))) - 1310720));
  endfunction

  function automatic logic [14:0] pick_heading();
    if ($urandom_range(9) == 0) return 15'($urandom);
    return 15'($signed($urandom_range(25736)) - 12868);
  endfunction

  tick_row_t dir_rows[$];

  initial begin
    cmd_t none;
    longint tx, ty;
    none = '{lin: '0, ang: '0, arr: 1'b0};
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    pose_x_i = '0;
    pose_y_i = '0;
    heading_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_TARGET_X;
    cfg_data_i = '0;
    err_cnt = 0;
    idle_cnt = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    cur_typed = 0;
    tgt_x = 655360; tgt_y = 655360; look_off = 6554; lqr_k = 177053;
    dt_q = 6554; q_noise = 655; r_noise = 3277;
    est_x = 0; est_y = 0; est_var = 65536; est_seeded = 0;

    // look-ahead point lands on the target: seeded estimate arrives at once
    dir_rows.push_back('{655360 - 6554, 655360, 15'sd0, 1, '{'0, '0, 1'b1}});
    dir_rows.push_back('{655360, 655360 - 6554, 15'sd6434, 0, none});
    dir_rows.push_back('{0, 0, 15'sd0, 0, none});
    dir_rows.push_back('{0, 0, 15'sd12868, 0, none});
    dir_rows.push_back('{0, 0, -15'sd12868, 0, none});
    dir_rows.push_back('{0, 0, 15'sd16383, 0, none});
    dir_rows.push_back('{0, 0, -15'sd16384, 0, none});
    dir_rows.push_back('{32'sh7fffffff, 32'sh7fffffff, 15'sd3217, 0, none});
    dir_rows.push_back('{32'sh80000000, 32'sh80000000, -15'sd9651, 0, none});
    dir_rows.push_back('{32'sh7fffffff, 32'sh80000000, 15'sd0, 0, none});
    dir_rows.push_back('{32'sh80000000, 32'sh7fffffff, 15'sd12868, 0, none});
    dir_rows.push_back('{-32'sd1, 32'sd1, -15'sd1, 0, none});
    dir_rows.push_back('{655360, 655360, 15'sd0, 0, none});
    dir_rows.push_back('{655360 - 6554, 655360, 15'sd0, 0, none});
    dir_rows.push_back('{655360 - 6554, 655360, 15'sd0, 0, none});

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i])
      send_tick(dir_rows[i].px, dir_rows[i].py, dir_rows[i].hd, dir_rows[i].typed,
                dir_rows[i].cmd);
    drain();

    for (int ph = 1; ph <= 8; ph++) begin
      tx = longint'($signed($urandom_range(6553600))) - 3276800;
      ty = longint'($signed($urandom_range(6553600))) - 3276800;
      case (ph)
        2: write_all(64'sd2147483647, -64'sd2147483648, 1, 1310720, 65536, 65536, 65536);
        3: write_all(0, 0, 131072, 0, 1, 0, 1);
        4: write_all(tx, ty, 0, $urandom_range(1310720), $urandom_range(1, 65536),
                     $urandom_range(65536), $urandom_range(1, 65536));
        5: write_all(tx, ty, $urandom_range(1, 131072), $urandom_range(1310720),
                     $urandom_range(1, 65536), 0, 0);
        default: write_all(tx, ty, $urandom_range(1, 131072), $urandom_range(1310720),
                           $urandom_range(1, 65536), $urandom_range(65536),
                           $urandom_range(1, 65536));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 53; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 53; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      if (ph == 6) hold_left = LONG_HOLD;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 7 && n == PHASE_ITEMS / 2) begin
          in_valid_i <= 1'b0;
          wait (cmd_q.size() == 0);
          @(negedge clk_i);
        end
        send_tick(pick_coord(tgt_x), pick_coord(tgt_y), pick_heading(), 0, none);
      end
      drain();
    end

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
